@@ sv/three_channel_gated_root_counter_macros.svh @@
// assertion helpers shared by the counter block
`ifndef THREE_CHANNEL_GATED_ROOT_COUNTER_MACROS_SVH
`define THREE_CHANNEL_GATED_ROOT_COUNTER_MACROS_SVH

// plain property, checked on every edge outside reset
`define TGRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition now implies a consequence on the next edge
`define TGRC_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

@@ sv/tgrc_pkg.sv @@
// ----------------------------------------------------------------------------
// tgrc_pkg
// Types, mode bit positions and codes of the gated root counter block.
// ----------------------------------------------------------------------------
package tgrc_pkg;

  localparam int TIMER_COUNT     = 3;
  localparam int PRESCALE_DIVIDE = 8;
  localparam int PS_W            = $clog2(PRESCALE_DIVIDE);
  localparam int CNT_W           = 16;
  localparam int MODE_W          = 10;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // mode register bit positions
  localparam int MB_SYNC_EN = 0;
  localparam int MB_SM_LO   = 1;
  localparam int MB_RST_TGT = 3;
  localparam int MB_IRQ_TGT = 4;
  localparam int MB_IRQ_OVF = 5;
  localparam int MB_REPEAT  = 6;
  localparam int MB_TOGGLE  = 7;
  localparam int MB_EXT_SRC = 8;
  localparam int MB_DIV     = 9;

  // timer that has the prescaler and its own sync rules
  localparam logic [1:0] TMR_PRESCALED = 2'd2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_GATE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    SM_PAUSE     = 2'd0,
    SM_RESET     = 2'd1,
    SM_RESET_RUN = 2'd2,
    SM_FREE      = 2'd3
  } sync_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_ZERO   = 3'd0,
    CFG_MODE_ONE    = 3'd1,
    CFG_MODE_TWO    = 3'd2,
    CFG_TARGET_ZERO = 3'd3,
    CFG_TARGET_ONE  = 3'd4,
    CFG_TARGET_TWO  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       opcode;
    logic [1:0] timer_index;
    logic       gate_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       irq_request;
    logic [CNT_W-1:0] count_zero;
    logic [CNT_W-1:0] count_one;
    logic [CNT_W-1:0] count_two;
    logic [2:0]       irq_level;
    logic [2:0]       target_flags;
    logic [2:0]       overflow_flags;
  } out_item_t;

  // per timer control from the top level
  typedef struct packed {
    logic step;
    logic tick;
    logic gate;
    logic gate_level;
    logic mode_wr;
    logic sync_wr;
  } tmr_ctrl_t;

  // per timer state after the current beat
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             req;
    logic             level;
    logic             thit;
    logic             ohit;
  } tmr_stat_t;

endpackage

@@ sv/tgrc_timer.sv @@
// ----------------------------------------------------------------------------
// tgrc_timer
// One 16-bit root counter: gate sync, target and overflow compare, irq logic.
// ----------------------------------------------------------------------------
module tgrc_timer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                tmr_idx_i,
  input  logic [tgrc_pkg::MODE_W-1:0] mode_i,
  input  logic [tgrc_pkg::CNT_W-1:0]  target_i,
  input  tgrc_pkg::tmr_ctrl_t       ctrl_i,
  output tgrc_pkg::tmr_stat_t       stat_o
);
  import tgrc_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic sync_q, sync_d;
  logic gate_q, gate_d;
  logic given_q, given_d;
  logic level_q, level_d;
  logic thit_q, thit_d;
  logic ohit_q, ohit_d;

  sync_mode_e       sm;
  logic             run;
  logic [CNT_W-1:0] inc;
  logic [CNT_W-1:0] after_tgt;
  logic             hit;
  logic             ovf;
  logic             irq;
  logic             req;

  assign sm = sync_mode_e'(mode_i[MB_SM_LO +: 2]);

  always_comb begin
    run = 1'b1;
    if (sync_q) begin
      if (tmr_idx_i != TMR_PRESCALED) begin
        if (sm == SM_PAUSE && gate_q) run = 1'b0;
        if ((sm == SM_RESET_RUN || sm == SM_FREE) && !gate_q) run = 1'b0;
      end else if (sm == SM_PAUSE || sm == SM_FREE) begin
        run = 1'b0;
      end
    end
  end

  assign inc       = cnt_q + 1'b1;
  assign hit       = (inc == target_i) || (target_i == '0 && inc != '0);
  assign after_tgt = (hit && mode_i[MB_RST_TGT]) ? '0 : inc;
  assign ovf       = (after_tgt == CNT_MAX);
  assign irq       = (hit && mode_i[MB_IRQ_TGT]) || (ovf && mode_i[MB_IRQ_OVF]);

  always_comb begin
    cnt_d   = cnt_q;
    sync_d  = sync_q;
    gate_d  = gate_q;
    given_d = given_q;
    level_d = level_q;
    thit_d  = thit_q;
    ohit_d  = ohit_q;
    req     = 1'b0;
    if (ctrl_i.tick && run) begin
      cnt_d = ovf ? '0 : after_tgt;
      if (hit) thit_d = 1'b1;
      if (ovf) ohit_d = 1'b1;
      if (irq) begin
        if (mode_i[MB_TOGGLE]) begin
          level_d = !level_q;
        end else begin
          if (mode_i[MB_REPEAT] || !given_q) begin
            given_d = 1'b1;
            req     = 1'b1;
          end
          level_d = 1'b1;
        end
      end
    end
    if (ctrl_i.gate) begin
      gate_d = ctrl_i.gate_level;
      if (sync_q && ctrl_i.gate_level) begin
        if (sm == SM_RESET || sm == SM_RESET_RUN) cnt_d = '0;
        if (sm == SM_FREE) sync_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sync_q  <= 1'b0;
      gate_q  <= 1'b0;
      given_q <= 1'b0;
      level_q <= 1'b0;
      thit_q  <= 1'b0;
      ohit_q  <= 1'b0;
    end else if (ctrl_i.mode_wr) begin
      sync_q <= ctrl_i.sync_wr;
    end else if (ctrl_i.step) begin
      cnt_q   <= cnt_d;
      sync_q  <= sync_d;
      gate_q  <= gate_d;
      given_q <= given_d;
      level_q <= level_d;
      thit_q  <= thit_d;
      ohit_q  <= ohit_d;
    end
  end

  assign stat_o.count = cnt_d;
  assign stat_o.req   = req;
  assign stat_o.level = level_d;
  assign stat_o.thit  = thit_d;
  assign stat_o.ohit  = ohit_d;

endmodule

@@ sv/three_channel_gated_root_counter.sv @@
// ----------------------------------------------------------------------------
// three_channel_gated_root_counter
// Three gated 16-bit root counters stepped by tick and gate-change beats.
// ----------------------------------------------------------------------------
// path: input register, then result register; throughput: one beat per cycle
//   unless out_ready_i stalls a full result; the input and result registers
//   decouple the channels, each timer updates in one compare-and-increment pass
// reset: asynchronous, clears counters, flags, prescaler and mode/target regs
// ----------------------------------------------------------------------------
module three_channel_gated_root_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tgrc_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tgrc_pkg::out_item_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [tgrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tgrc_pkg::CNT_W-1:0]   cfg_data_i
);
  import tgrc_pkg::*;

  `include "three_channel_gated_root_counter_macros.svh"

  logic [MODE_W-1:0] mode_q [3];
  logic [CNT_W-1:0]  target_q [3];

  logic      in_vld_q, out_vld_q;
  in_item_t  in_q;
  out_item_t out_q, res;
  logic      move;
  logic      is_tick;

  logic [PS_W-1:0] ps_q, ps_d;
  logic            ps_wrap;

  tmr_ctrl_t ctrl [3];
  tmr_stat_t stat [3];
  logic      tick_en [3];

  assign move       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || move;
  assign is_tick    = (in_q.opcode == OP_TICK);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        mode_q[i]   <= '0;
        target_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE_ZERO:   mode_q[0]   <= cfg_data_i[MODE_W-1:0];
        CFG_MODE_ONE:    mode_q[1]   <= cfg_data_i[MODE_W-1:0];
        CFG_MODE_TWO:    mode_q[2]   <= cfg_data_i[MODE_W-1:0];
        CFG_TARGET_ZERO: target_q[0] <= cfg_data_i;
        CFG_TARGET_ONE:  target_q[1] <= cfg_data_i;
        CFG_TARGET_TWO:  target_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  // prescaler for the third timer, counts every tick while divide is on
  assign ps_wrap = (ps_q == PS_W'(PRESCALE_DIVIDE - 1));

  always_comb begin
    ps_d = ps_q;
    if (is_tick && mode_q[2][MB_DIV]) ps_d = ps_wrap ? '0 : ps_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= '0;
    end else if (move) begin
      ps_q <= ps_d;
    end
  end

  assign tick_en[0] = is_tick && !mode_q[0][MB_EXT_SRC];
  assign tick_en[1] = is_tick && !mode_q[1][MB_EXT_SRC];
  assign tick_en[2] = is_tick && (!mode_q[2][MB_DIV] || ps_wrap);

  for (genvar g = 0; g < 3; g++) begin : g_tmr
    if (g < TIMER_COUNT) begin : g_on
      assign ctrl[g].step       = move;
      assign ctrl[g].tick       = tick_en[g];
      assign ctrl[g].gate       = !is_tick && (in_q.timer_index == 2'(g));
      assign ctrl[g].gate_level = in_q.gate_level;
      assign ctrl[g].mode_wr    = cfg_we_i && (cfg_index_i == CFG_IDX_W'(g));
      assign ctrl[g].sync_wr    = cfg_data_i[MB_SYNC_EN];

      tgrc_timer u_tmr (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .tmr_idx_i (2'(g)),
        .mode_i    (mode_q[g]),
        .target_i  (target_q[g]),
        .ctrl_i    (ctrl[g]),
        .stat_o    (stat[g])
      );
    end else begin : g_off
      assign ctrl[g] = '0;
      assign stat[g] = '0;
    end
  end

  always_comb begin
    res.count_zero = stat[0].count;
    res.count_one  = stat[1].count;
    res.count_two  = stat[2].count;
    for (int i = 0; i < 3; i++) begin
      res.irq_request[i]    = stat[i].req;
      res.irq_level[i]      = stat[i].level;
      res.target_flags[i]   = stat[i].thit;
      res.overflow_flags[i] = stat[i].ohit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `TGRC_ASSERT(a_ready_when_free, clk_i, rst_ni,
    (!out_vld_q || out_ready_i) |-> in_ready_o, "input stalled with free result slot")
  `TGRC_ASSERT_NEXT(a_gate_no_irq, clk_i, rst_ni,
    move && !is_tick, out_q.irq_request == '0, "gate beat raised an irq request")
  `TGRC_ASSERT(a_ps_range, clk_i, rst_ni,
    ps_q <= PS_W'(PRESCALE_DIVIDE - 1), "prescaler out of range")
  `TGRC_ASSERT_NEXT(a_move_fills_out, clk_i, rst_ni,
    move, out_vld_q, "step did not fill result register")

endmodule
